// File: rtl/cis_pkg.sv
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types, character codes and the C keyword table of the identifier
// scanner.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int WORD_BUFFER_SIZE_DEF = 128;

  localparam int KW_COUNT = 37;
  localparam int KW_CHARS = 16;              // table row width in characters
  localparam int KW_W     = 8 * KW_CHARS;

  // Rows are right-justified: the last character of a word sits in byte 0.
  localparam logic [KW_W-1:0] KW_TABLE [KW_COUNT] = '{
    KW_W'("auto"),     KW_W'("break"),    KW_W'("case"),      KW_W'("char"),
    KW_W'("const"),    KW_W'("continue"), KW_W'("default"),   KW_W'("do"),
    KW_W'("double"),   KW_W'("else"),     KW_W'("enum"),      KW_W'("extern"),
    KW_W'("float"),    KW_W'("for"),      KW_W'("goto"),      KW_W'("if"),
    KW_W'("inline"),   KW_W'("int"),      KW_W'("long"),      KW_W'("register"),
    KW_W'("restrict"), KW_W'("return"),   KW_W'("short"),     KW_W'("signed"),
    KW_W'("sizeof"),   KW_W'("static"),   KW_W'("struct"),    KW_W'("switch"),
    KW_W'("typedef"),  KW_W'("union"),    KW_W'("unsigned"),  KW_W'("void"),
    KW_W'("volatile"), KW_W'("while"),    KW_W'("_Bool"),     KW_W'("_Complex"),
    KW_W'("_Imaginary")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd6, 4'd3, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
    4'd8, 4'd5, 4'd5, 4'd8, 4'd10
  };

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_USCORE  = 8'h5F;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4,
    MODE_QUOTE  = 3'd5,
    MODE_QESC   = 3'd6,
    MODE_IDENT  = 3'd7
  } mode_t;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       kw_flag;
  } result_t;

  function automatic logic is_start(input logic [7:0] c);
    is_start = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c == CH_USCORE);
  endfunction

  function automatic logic is_part(input logic [7:0] c);
    is_part = is_start(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

// File: rtl/cis_kw_match.sv
// ----------------------------------------------------------------------------
// cis_kw_match
// Keyword candidate narrowing and final keyword hit, all 37 keywords compared
// in parallel.
// ----------------------------------------------------------------------------
module cis_kw_match import cis_pkg::*; #(
  parameter int WORD_BUFFER_SIZE = WORD_BUFFER_SIZE_DEF
) (
  input  logic [KW_COUNT-1:0]                 cand_in,
  input  logic [$clog2(WORD_BUFFER_SIZE)-1:0] pos,
  input  logic [7:0]                          char_in,
  output logic [KW_COUNT-1:0]                 cand_out,
  input  logic [KW_COUNT-1:0]                 cand_cur,
  input  logic [$clog2(WORD_BUFFER_SIZE)-1:0] len_cur,
  output logic                                hit
);

  localparam int LEN_W = $clog2(WORD_BUFFER_SIZE);

  always_comb begin
    logic [3:0] idx;
    cand_out = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      // byte position of character 'pos' in a right-justified row
      idx = KW_LEN[k] - 4'd1 - pos[3:0];
      cand_out[k] = cand_in[k] && (pos < LEN_W'(KW_LEN[k])) &&
                    (KW_TABLE[k][{idx, 3'b000} +: 8] == char_in);
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand_cur[k] && (len_cur == LEN_W'(KW_LEN[k]))) begin
        hit = 1'b1;
      end
    end
  end

endmodule

// File: rtl/cis_scan_core.sv
// ----------------------------------------------------------------------------
// cis_scan_core
// Lexical mode machine, word length and keyword candidates, and the result
// register toward the output channel.
// ----------------------------------------------------------------------------
module cis_scan_core import cis_pkg::*; #(
  parameter int WORD_BUFFER_SIZE = WORD_BUFFER_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  in_item_t item,
  output logic     advance,
  output logic     out_tvalid,
  input  logic     out_tready,
  output result_t  out_res
);

  localparam int LEN_W = $clog2(WORD_BUFFER_SIZE);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BUFFER_SIZE - 1);

  mode_t               mode_r, mode_nxt;
  logic                qs_r, qs_nxt;
  logic [LEN_W-1:0]    wlen_r, wlen_nxt;
  logic [KW_COUNT-1:0] cand_r, cand_nxt;
  logic                out_valid_r;
  result_t             out_res_r;

  logic                fire;
  logic                emit;
  result_t             res;
  logic [7:0]          c;
  logic [KW_COUNT-1:0] narrow_in, narrow_out;
  logic [LEN_W-1:0]    narrow_pos;
  logic                kw_hit;
  mode_t               norm_mode;
  logic                is_q;

  assign advance = !out_valid_r || out_tready;
  assign fire    = item_valid && advance;
  assign c       = item.byte_req;

  assign narrow_in  = (mode_r == MODE_IDENT) ? cand_r : '1;
  assign narrow_pos = (mode_r == MODE_IDENT) ? wlen_r : '0;

  cis_kw_match #(
    .WORD_BUFFER_SIZE (WORD_BUFFER_SIZE)
  ) u_kw_match (
    .cand_in  (narrow_in),
    .pos      (narrow_pos),
    .char_in  (c),
    .cand_out (narrow_out),
    .cand_cur (cand_r),
    .len_cur  (wlen_r),
    .hit      (kw_hit)
  );

  // normal-code decode of the current byte
  always_comb begin
    is_q = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    if (c == CH_SLASH) begin
      norm_mode = MODE_SLASH;
    end else if (is_q) begin
      norm_mode = MODE_QUOTE;
    end else if (is_start(c)) begin
      norm_mode = MODE_IDENT;
    end else begin
      norm_mode = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      qs_r   <= 1'b0;
      wlen_r <= '0;
      cand_r <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      qs_r   <= qs_nxt;
      wlen_r <= wlen_nxt;
      cand_r <= cand_nxt;
    end
  end

  always_comb begin
    logic take_normal;
    mode_nxt    = mode_r;
    qs_nxt      = qs_r;
    wlen_nxt    = wlen_r;
    cand_nxt    = cand_r;
    emit        = 1'b0;
    res         = '0;
    take_normal = 1'b0;

    if (item.end_of_input) begin
      if (mode_r == MODE_IDENT) begin
        emit        = 1'b1;
        res.kind    = KIND_END;
        res.kw_flag = kw_hit;
      end
      mode_nxt = MODE_NORMAL;
      qs_nxt   = 1'b0;
      wlen_nxt = '0;
      cand_nxt = '0;
    end else begin
      unique case (mode_r)
        MODE_IDENT: begin
          if (is_part(c)) begin
            if (wlen_r < LEN_MAX) begin
              cand_nxt       = narrow_out;
              wlen_nxt       = wlen_r + 1'b1;
              emit           = 1'b1;
              res.kind       = KIND_CHAR;
              res.char_value = c;
            end
          end else begin
            emit        = 1'b1;
            res.kind    = KIND_END;
            res.kw_flag = kw_hit;
            wlen_nxt    = '0;
            cand_nxt    = '0;
            take_normal = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (c == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            take_normal = 1'b1;
          end
        end
        MODE_LINE: begin
          if (c == CH_NL) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) begin
            mode_nxt = MODE_BSTAR;
          end
        end
        MODE_BSTAR: begin
          if (c == CH_SLASH) begin
            mode_nxt = MODE_NORMAL;
          end else if (c != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
        MODE_QUOTE: begin
          if (c == CH_BSLASH) begin
            mode_nxt = MODE_QESC;
          end else if (c == (qs_r ? CH_SQUOTE : CH_DQUOTE)) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_QESC: begin
          mode_nxt = MODE_QUOTE;
        end
        MODE_NORMAL: begin
          take_normal = 1'b1;
        end
      endcase

      if (take_normal) begin
        mode_nxt = norm_mode;
        if (is_q) begin
          qs_nxt = (c == CH_SQUOTE);
        end
        // an identifier byte never reaches here from an ending word
        if (norm_mode == MODE_IDENT) begin
          cand_nxt       = narrow_out;
          wlen_nxt       = LEN_W'(1);
          emit           = 1'b1;
          res.kind       = KIND_CHAR;
          res.char_value = c;
        end
      end
    end
  end

  // result register: refill whenever the slot is free or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

endmodule

// File: rtl/c_identifier_scanner.sv
// ----------------------------------------------------------------------------
// c_identifier_scanner
// Finds identifiers in a C source byte stream, skipping comments and quotes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one source byte per transfer in in_tdata; in_tlast marks
//   end of file (byte ignored), which closes a pending word and restarts the
//   scanner.
//   Output channel: zero or one result per input byte. out_tuser[0] is the
//   kind (0 character, 1 end of word); out_tdata carries the character, and
//   out_tuser[1] flags a C keyword on an end-of-word result.
//   Pipeline: two register stages, the input register and then the result
//   register, which drives out_tvalid for the result of a taken byte.
//   Throughput: one byte per cycle when not stalled; the mode update and
//   the 37-way keyword compare sit between the input and result registers.
//   Reset: synchronous, rst_n low; scanner returns to normal code, both
//   registers empty. No clearing pass is needed.
//   Stall: a held result stalls the input register; the input stays ready
//   while the register is free or drains in the same cycle.
// ----------------------------------------------------------------------------
module c_identifier_scanner import cis_pkg::*; #(
  parameter int WORD_BUFFER_SIZE = WORD_BUFFER_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_req
  input  logic       in_tlast,   // end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_value
  output logic [1:0] out_tuser   // [0] kind, [1] kw_flag
);

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     advance;
  result_t  res;

  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= '{byte_req: in_tdata, end_of_input: in_tlast};
    end
  end

  cis_scan_core #(
    .WORD_BUFFER_SIZE (WORD_BUFFER_SIZE)
  ) u_scan_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = res.char_value;
  assign out_tuser = {res.kw_flag, res.kind};

endmodule
